/* rtl/rsdes_pkg.sv */
// ----------------------------------------------------------------------------
// rsdes_pkg
// Types and constants shared by the RTCP SDES packet parser modules.
// ----------------------------------------------------------------------------
package rsdes_pkg;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_SSRC   = 3'd1,
    PH_TYPE   = 3'd2,
    PH_LEN    = 3'd3,
    PH_VALUE  = 3'd4,
    PH_PAD    = 3'd5,
    PH_IGNORE = 3'd6
  } phase_t;

  localparam logic [2:0] ROLE_HEADER  = 3'd0;
  localparam logic [2:0] ROLE_SSRC    = 3'd1;
  localparam logic [2:0] ROLE_TYPE    = 3'd2;
  localparam logic [2:0] ROLE_LENGTH  = 3'd3;
  localparam logic [2:0] ROLE_VALUE   = 3'd4;
  localparam logic [2:0] ROLE_END     = 3'd5;
  localparam logic [2:0] ROLE_PAD     = 3'd6;
  localparam logic [2:0] ROLE_IGNORED = 3'd7;

  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_HDR_SHORT  = 3'd1;
  localparam logic [2:0] ERR_SSRC_SHORT = 3'd2;
  localparam logic [2:0] ERR_ITEM_SHORT = 3'd3;
  localparam logic [2:0] ERR_NO_END     = 3'd4;
  localparam logic [2:0] ERR_PAD_BYTE   = 3'd5;
  localparam logic [2:0] ERR_PAD_SHORT  = 3'd6;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0] byte_role;
    logic [4:0] chunk_index;
    logic [7:0] item_kind;
    logic       packet_done;
    logic       packet_ok;
    logic [2:0] error_code;
  } out_item_t;

  // Classified byte as it waits in the queue.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       is_null;
  } q_item_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic full;
    logic not_empty;
  } q_status_t;

endpackage

/* rtl/rsdes_front.sv */
// ----------------------------------------------------------------------------
// rsdes_front
// Input side: accepts bytes, marks null octets and pushes them to the queue.
// ----------------------------------------------------------------------------
module rsdes_front (
  input  rsdes_pkg::in_item_t  in_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rsdes_pkg::q_status_t q_status,
  output logic                 push,
  output rsdes_pkg::q_item_t   push_item
);

  assign in_ready = !q_status.full;
  assign push     = in_valid && !q_status.full;

  always_comb begin
    push_item.data_byte = in_data.data_byte;
    push_item.last_byte = in_data.last_byte;
    push_item.is_null   = (in_data.data_byte == 8'd0);
  end

endmodule

/* rtl/rsdes_queue.sv */
// ----------------------------------------------------------------------------
// rsdes_queue
// Short register queue between the front and the back of the parser.
// ----------------------------------------------------------------------------
module rsdes_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  rsdes_pkg::q_item_t   push_item,
  input  logic                 pop,
  output rsdes_pkg::q_item_t   head_item,
  output rsdes_pkg::q_status_t status
);

  rsdes_pkg::q_item_t                 mem_r [rsdes_pkg::QDEPTH];
  logic [rsdes_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [rsdes_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [rsdes_pkg::QCNT_W-1:0]       count_r, count_nxt;

  localparam logic [rsdes_pkg::QPTR_W-1:0] LAST_PTR =
    rsdes_pkg::QPTR_W'(rsdes_pkg::QDEPTH - 1);
  localparam logic [rsdes_pkg::QCNT_W-1:0] FULL_CNT =
    rsdes_pkg::QCNT_W'(rsdes_pkg::QDEPTH);

  assign status.full      = (count_r == FULL_CNT);
  assign status.not_empty = (count_r != '0);
  assign head_item        = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

/* rtl/rsdes_back.sv */
// ----------------------------------------------------------------------------
// rsdes_back
// Parser state machine: tags each queued byte, decides the packet verdict
// and holds the result in an output register.
// ----------------------------------------------------------------------------
module rsdes_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rsdes_pkg::q_status_t q_status,
  input  rsdes_pkg::q_item_t   head_item,
  output logic                 pop,
  output rsdes_pkg::out_item_t out_data,
  output logic                 out_valid,
  input  logic                 out_ready
);

  rsdes_pkg::phase_t    phase_r, phase_nxt;
  logic [7:0]           cnt_r, cnt_nxt;
  logic [1:0]           mod4_r, mod4_nxt;
  logic [4:0]           left_r, left_nxt;
  logic [4:0]           chunk_r, chunk_nxt;
  logic [7:0]           kind_r, kind_nxt;
  logic                 out_valid_r;
  rsdes_pkg::out_item_t out_r;
  rsdes_pkg::out_item_t res;

  logic       last, is_null;
  logic [7:0] d;
  logic [4:0] left_eff, left_dec;
  logic [7:0] cnt_inc, cnt_dec;
  logic [1:0] mod4_inc, need;

  assign d        = head_item.data_byte;
  assign last     = head_item.last_byte;
  assign is_null  = head_item.is_null;
  // The chunk count arrives on the first header byte and is used on the fourth.
  assign left_eff = (cnt_r == 8'd0) ? d[4:0] : left_r;
  assign left_dec = left_r - 5'd1;
  assign cnt_inc  = cnt_r + 8'd1;
  assign cnt_dec  = cnt_r - 8'd1;
  assign mod4_inc = mod4_r + 2'd1;
  assign need     = 2'd0 - mod4_inc;

  assign pop       = q_status.not_empty && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Result of the byte at the head of the queue.
  always_comb begin
    res             = '0;
    res.byte_role   = rsdes_pkg::ROLE_IGNORED;
    res.error_code  = rsdes_pkg::ERR_NONE;
    unique case (phase_r)
      rsdes_pkg::PH_HEADER: begin
        res.byte_role = rsdes_pkg::ROLE_HEADER;
        if (cnt_r >= 8'd3) begin
          if (left_eff == 5'd0) begin
            res.packet_done = 1'b1;
            res.packet_ok   = 1'b1;
          end else if (last) begin
            res.packet_done = 1'b1;
            res.error_code  = rsdes_pkg::ERR_SSRC_SHORT;
          end
        end else if (last) begin
          res.packet_done = 1'b1;
          res.error_code  = rsdes_pkg::ERR_HDR_SHORT;
        end
      end
      rsdes_pkg::PH_SSRC: begin
        res.byte_role   = rsdes_pkg::ROLE_SSRC;
        res.chunk_index = chunk_r;
        if (last) begin
          res.packet_done = 1'b1;
          res.error_code  = (cnt_inc >= 8'd4) ? rsdes_pkg::ERR_NO_END
                                              : rsdes_pkg::ERR_SSRC_SHORT;
        end
      end
      rsdes_pkg::PH_TYPE: begin
        res.chunk_index = chunk_r;
        if (is_null) begin
          res.byte_role = rsdes_pkg::ROLE_END;
          if (need == 2'd0) begin
            if (left_dec == 5'd0) begin
              res.packet_done = 1'b1;
              res.packet_ok   = 1'b1;
            end else if (last) begin
              res.packet_done = 1'b1;
              res.error_code  = rsdes_pkg::ERR_SSRC_SHORT;
            end
          end else if (last) begin
            res.packet_done = 1'b1;
            res.error_code  = rsdes_pkg::ERR_PAD_SHORT;
          end
        end else begin
          res.byte_role = rsdes_pkg::ROLE_TYPE;
          res.item_kind = d;
          if (last) begin
            res.packet_done = 1'b1;
            res.error_code  = rsdes_pkg::ERR_ITEM_SHORT;
          end
        end
      end
      rsdes_pkg::PH_LEN: begin
        res.byte_role   = rsdes_pkg::ROLE_LENGTH;
        res.chunk_index = chunk_r;
        res.item_kind   = kind_r;
        if (last) begin
          res.packet_done = 1'b1;
          res.error_code  = is_null ? rsdes_pkg::ERR_NO_END : rsdes_pkg::ERR_ITEM_SHORT;
        end
      end
      rsdes_pkg::PH_VALUE: begin
        res.byte_role   = rsdes_pkg::ROLE_VALUE;
        res.chunk_index = chunk_r;
        res.item_kind   = kind_r;
        if (last) begin
          res.packet_done = 1'b1;
          res.error_code  = (cnt_dec == 8'd0) ? rsdes_pkg::ERR_NO_END
                                              : rsdes_pkg::ERR_ITEM_SHORT;
        end
      end
      rsdes_pkg::PH_PAD: begin
        res.byte_role   = rsdes_pkg::ROLE_PAD;
        res.chunk_index = chunk_r;
        if (!is_null) begin
          res.packet_done = 1'b1;
          res.error_code  = rsdes_pkg::ERR_PAD_BYTE;
        end else if (cnt_dec == 8'd0) begin
          if (left_dec == 5'd0) begin
            res.packet_done = 1'b1;
            res.packet_ok   = 1'b1;
          end else if (last) begin
            res.packet_done = 1'b1;
            res.error_code  = rsdes_pkg::ERR_SSRC_SHORT;
          end
        end else if (last) begin
          res.packet_done = 1'b1;
          res.error_code  = rsdes_pkg::ERR_PAD_SHORT;
        end
      end
      rsdes_pkg::PH_IGNORE: begin
        res.byte_role = rsdes_pkg::ROLE_IGNORED;
      end
      default: begin
        res.byte_role = rsdes_pkg::ROLE_IGNORED;
      end
    endcase
  end

  // Parser state update for the byte at the head of the queue.
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    mod4_nxt  = mod4_r;
    left_nxt  = left_r;
    chunk_nxt = chunk_r;
    kind_nxt  = kind_r;
    unique case (phase_r)
      rsdes_pkg::PH_HEADER: begin
        left_nxt = left_eff;
        if (cnt_r >= 8'd3) begin
          phase_nxt = rsdes_pkg::PH_SSRC;
          cnt_nxt   = 8'd0;
          chunk_nxt = 5'd0;
        end else begin
          cnt_nxt = cnt_inc;
        end
      end
      rsdes_pkg::PH_SSRC: begin
        cnt_nxt = cnt_inc;
        if (cnt_inc >= 8'd4) begin
          mod4_nxt  = 2'd0;
          cnt_nxt   = 8'd0;
          phase_nxt = rsdes_pkg::PH_TYPE;
        end
      end
      rsdes_pkg::PH_TYPE: begin
        mod4_nxt = mod4_inc;
        if (is_null) begin
          kind_nxt = 8'd0;
          if (need == 2'd0) begin
            left_nxt  = left_dec;
            chunk_nxt = chunk_r + 5'd1;
            cnt_nxt   = 8'd0;
            phase_nxt = rsdes_pkg::PH_SSRC;
          end else begin
            cnt_nxt   = {6'd0, need};
            phase_nxt = rsdes_pkg::PH_PAD;
          end
        end else begin
          kind_nxt  = d;
          phase_nxt = rsdes_pkg::PH_LEN;
        end
      end
      rsdes_pkg::PH_LEN: begin
        mod4_nxt = mod4_inc;
        if (is_null) begin
          phase_nxt = rsdes_pkg::PH_TYPE;
        end else begin
          cnt_nxt   = d;
          phase_nxt = rsdes_pkg::PH_VALUE;
        end
      end
      rsdes_pkg::PH_VALUE: begin
        mod4_nxt = mod4_inc;
        cnt_nxt  = cnt_dec;
        if (cnt_dec == 8'd0) begin
          phase_nxt = rsdes_pkg::PH_TYPE;
        end
      end
      rsdes_pkg::PH_PAD: begin
        mod4_nxt = mod4_inc;
        cnt_nxt  = cnt_dec;
        if (cnt_dec == 8'd0) begin
          left_nxt  = left_dec;
          chunk_nxt = chunk_r + 5'd1;
          kind_nxt  = 8'd0;
          phase_nxt = rsdes_pkg::PH_SSRC;
        end
      end
      rsdes_pkg::PH_IGNORE: begin
        phase_nxt = rsdes_pkg::PH_IGNORE;
      end
      default: begin
        phase_nxt = rsdes_pkg::PH_IGNORE;
      end
    endcase
    // A verdict on the final buffer byte, or the final byte while ignoring,
    // rearms the parser for a new packet; otherwise later bytes are ignored.
    if ((res.packet_done || phase_r == rsdes_pkg::PH_IGNORE) && last) begin
      phase_nxt = rsdes_pkg::PH_HEADER;
      cnt_nxt   = 8'd0;
      mod4_nxt  = 2'd0;
      left_nxt  = 5'd0;
      chunk_nxt = 5'd0;
      kind_nxt  = 8'd0;
    end else if (res.packet_done) begin
      phase_nxt = rsdes_pkg::PH_IGNORE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= rsdes_pkg::PH_HEADER;
      cnt_r       <= 8'd0;
      mod4_r      <= 2'd0;
      left_r      <= 5'd0;
      chunk_r     <= 5'd0;
      kind_r      <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        phase_r     <= phase_nxt;
        cnt_r       <= cnt_nxt;
        mod4_r      <= mod4_nxt;
        left_r      <= left_nxt;
        chunk_r     <= chunk_nxt;
        kind_r      <= kind_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_r <= res;
    end
  end

endmodule

/* rtl/rtcp_sdes_packet_parser_top.sv */
// ----------------------------------------------------------------------------
// rtcp_sdes_packet_parser_top
// RTCP SDES packet parser: tags every byte and gives one verdict per packet.
// ----------------------------------------------------------------------------
// A byte is registered in the queue first, then its result in the output register.
// Throughput: one byte per cycle while out_ready does not stall the output register.
// A two-entry queue separates input and parser; the output register holds one.
// Reset (rst_n, synchronous, active low) empties the queue and output register
// and returns the parser to the first header byte of a new packet.
// ----------------------------------------------------------------------------
module rtcp_sdes_packet_parser_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rsdes_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rsdes_pkg::out_item_t out_data
);

  rsdes_pkg::q_status_t q_status;
  rsdes_pkg::q_item_t   push_item;
  rsdes_pkg::q_item_t   head_item;
  logic                 push;
  logic                 pop;

  rsdes_front u_front (
    .in_data   (in_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .q_status  (q_status),
    .push      (push),
    .push_item (push_item)
  );

  rsdes_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .status    (q_status)
  );

  rsdes_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_status  (q_status),
    .head_item (head_item),
    .pop       (pop),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

endmodule
